>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check prop in the same cycle whenever cond holds.
`define ASSERT_IMPLIES(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error("assertion failed");

// Check prop in the cycle after cond holds.
`define ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rstn, cond, prop)
`define ASSERT_NEXT(label, clk, rstn, cond, prop)

`endif

`endif

>>> rtl/wpc_pkg.sv
package wpc_pkg;

    // Map index width and the divider layout: two quotient bits per stage.
    localparam int IDX_BITS       = 10;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = IDX_BITS / BITS_PER_STAGE;

    // Color map selection.
    localparam logic [2:0] SCHEME_GRAY = 3'd0;
    localparam logic [2:0] SCHEME_JET  = 3'd1;
    localparam logic [2:0] SCHEME_HOT  = 3'd2;
    localparam logic [2:0] SCHEME_COLD = 3'd3;
    localparam logic [2:0] SCHEME_NONE = 3'd4;

    // Window position of a sample.
    localparam logic [1:0] CODE_IN   = 2'd0;
    localparam logic [1:0] CODE_LOW  = 2'd1;
    localparam logic [1:0] CODE_HIGH = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_SCHEME = 2'd0;
    localparam logic [1:0] REG_LOW    = 2'd1;
    localparam logic [1:0] REG_HIGH   = 2'd2;

    // Last index of each map.
    localparam logic [IDX_BITS-1:0] GRAY_LAST = 10'd255;
    localparam logic [IDX_BITS-1:0] JET_LAST  = 10'd510;
    localparam logic [IDX_BITS-1:0] HOT_LAST  = 10'd1020;

    typedef struct packed {
        logic [2:0] scheme;
        logic [1:0] code;
    } item_ctl_t;

    // Red sits in the low byte so the struct drops straight onto tdata.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } color_t;

    function automatic color_t mk_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        color_t c;
        c.red   = r;
        c.green = g;
        c.blue  = b;
        return c;
    endfunction

    // Left shift that turns 255*num into span*num for the selected map.
    function automatic logic [1:0] scale_shift(logic [2:0] scheme);
        logic [1:0] s;
        case (scheme)
            SCHEME_JET:  s = 2'd1;
            SCHEME_HOT:  s = 2'd2;
            SCHEME_COLD: s = 2'd2;
            default:     s = 2'd0;
        endcase
        return s;
    endfunction

    function automatic color_t jet_entry(logic [IDX_BITS-1:0] i);
        logic [IDX_BITS-1:0] k;
        color_t c;
        k = '0;
        if (i < 10'd128) begin
            c = mk_color(8'd0, i[7:0], 8'd128 + i[7:0]);
        end else if (i < 10'd256) begin
            k = i - 10'd127;
            c = mk_color(k[7:0], 8'd127 + k[7:0], 8'd255 - k[7:0]);
        end else if (i < 10'd383) begin
            k = i - 10'd255;
            c = mk_color(8'd128 + k[7:0], 8'd255 - k[7:0], 8'd127 - k[7:0]);
        end else if (i < 10'd447) begin
            k = i - 10'd382;
            c = mk_color(8'd255, 8'd128 - {k[6:0], 1'b0}, 8'd0);
        end else begin
            k = ((i > JET_LAST) ? JET_LAST : i) - 10'd446;
            c = mk_color(8'd255 - {k[6:0], 1'b0}, 8'd0, 8'd0);
        end
        return c;
    endfunction

    function automatic color_t hot_entry(logic [IDX_BITS-1:0] i);
        logic [IDX_BITS-1:0] k;
        color_t c;
        k = '0;
        if (i < 10'd256) begin
            c = mk_color(8'd0, i[7:0], 8'd255);
        end else if (i < 10'd511) begin
            k = 10'd510 - i;
            c = mk_color(8'd0, 8'd255, k[7:0]);
        end else if (i < 10'd766) begin
            k = i - 10'd511;
            c = mk_color(k[7:0], 8'd255, 8'd0);
        end else begin
            k = 10'd1021 - ((i > HOT_LAST) ? HOT_LAST : i);
            c = mk_color(8'd255, k[7:0], 8'd0);
        end
        return c;
    endfunction

    // Final color from map, window position and rounded index.
    function automatic color_t color_pick(item_ctl_t ctl, logic [IDX_BITS-1:0] idx);
        color_t c;
        c = mk_color(8'd0, 8'd0, 8'd0);
        case (ctl.scheme)
            SCHEME_GRAY: begin
                if (ctl.code == CODE_LOW)       c = mk_color(8'd0, 8'd0, 8'd0);
                else if (ctl.code == CODE_HIGH) c = mk_color(8'd255, 8'd255, 8'd255);
                else                            c = mk_color(idx[7:0], idx[7:0], idx[7:0]);
            end
            SCHEME_JET: begin
                if (ctl.code == CODE_LOW)       c = mk_color(8'd0, 8'd0, 8'd139);
                else if (ctl.code == CODE_HIGH) c = mk_color(8'd139, 8'd0, 8'd0);
                else                            c = jet_entry(idx);
            end
            SCHEME_HOT: begin
                if (ctl.code == CODE_LOW)       c = mk_color(8'd0, 8'd0, 8'd255);
                else if (ctl.code == CODE_HIGH) c = mk_color(8'd255, 8'd0, 8'd0);
                else                            c = hot_entry(idx);
            end
            SCHEME_COLD: begin
                if (ctl.code == CODE_LOW)       c = mk_color(8'd255, 8'd0, 8'd0);
                else if (ctl.code == CODE_HIGH) c = mk_color(8'd0, 8'd0, 8'd255);
                else                            c = hot_entry(HOT_LAST - idx);
            end
            default: begin
                c = mk_color(8'd0, 8'd0, 8'd0);
            end
        endcase
        return c;
    endfunction

endpackage

>>> rtl/wpc_front.sv
`include "assert_macros.svh"

module wpc_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        en,
    input  logic                                        in_valid,
    input  logic signed [SAMPLE_BITS-1:0]               sample,
    input  logic [2:0]                                  scheme,
    input  logic signed [SAMPLE_BITS-1:0]               win_low,
    input  logic signed [SAMPLE_BITS-1:0]               win_high,
    output logic                                        prod_valid,
    output logic [SAMPLE_BITS+wpc_pkg::IDX_BITS-1:0]    prod,
    output logic [SAMPLE_BITS-1:0]                      den,
    output wpc_pkg::item_ctl_t                          ctl
);

    localparam int PW = SAMPLE_BITS + wpc_pkg::IDX_BITS;

    logic signed [SAMPLE_BITS:0] num_wide;
    logic signed [SAMPLE_BITS:0] den_wide;
    wpc_pkg::item_ctl_t          ctl_next;

    logic                        a_valid_reg;
    logic [SAMPLE_BITS-1:0]      a_num_reg;
    logic [SAMPLE_BITS-1:0]      a_den_reg;
    wpc_pkg::item_ctl_t          a_ctl_reg;

    logic [PW-1:0]               p255;
    logic [PW-1:0]               prod_next;

    logic                        b_valid_reg;
    logic [PW-1:0]               b_prod_reg;
    logic [SAMPLE_BITS-1:0]      b_den_reg;
    wpc_pkg::item_ctl_t          b_ctl_reg;

    // Low-end test first: an empty or inverted window never lands inside.
    always_comb begin
        ctl_next.scheme = scheme;
        if (sample <= win_low) begin
            ctl_next.code = wpc_pkg::CODE_LOW;
        end else if (sample >= win_high) begin
            ctl_next.code = wpc_pkg::CODE_HIGH;
        end else begin
            ctl_next.code = wpc_pkg::CODE_IN;
        end
        num_wide = $signed({sample[SAMPLE_BITS-1], sample})
                 - $signed({win_low[SAMPLE_BITS-1], win_low});
        den_wide = $signed({win_high[SAMPLE_BITS-1], win_high})
                 - $signed({win_low[SAMPLE_BITS-1], win_low});
    end

    // 255*num as a shift and subtract, then scale to the map span.
    always_comb begin
        p255 = {2'b00, a_num_reg, 8'h00} - {{wpc_pkg::IDX_BITS{1'b0}}, a_num_reg};
        case (wpc_pkg::scale_shift(a_ctl_reg.scheme))
            2'd1:    prod_next = {p255[PW-2:0], 1'b0};
            2'd2:    prod_next = {p255[PW-3:0], 2'b00};
            default: prod_next = p255;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_num_reg  <= num_wide[SAMPLE_BITS-1:0];
            a_den_reg  <= den_wide[SAMPLE_BITS-1:0];
            a_ctl_reg  <= ctl_next;
            b_prod_reg <= prod_next;
            b_den_reg  <= a_den_reg;
            b_ctl_reg  <= a_ctl_reg;
        end
    end

    assign prod_valid = b_valid_reg;
    assign prod       = b_prod_reg;
    assign den        = b_den_reg;
    assign ctl        = b_ctl_reg;

    `ASSERT_NEXT(front_valid_moves, aclk, aresetn, a_valid_reg && en, b_valid_reg)

endmodule

>>> rtl/wpc_div.sv
`include "assert_macros.svh"

module wpc_div #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        en,
    input  logic                                        in_valid,
    input  logic [SAMPLE_BITS+wpc_pkg::IDX_BITS-1:0]    prod,
    input  logic [SAMPLE_BITS-1:0]                      den,
    input  wpc_pkg::item_ctl_t                          ctl_in,
    output logic                                        idx_valid,
    output logic [wpc_pkg::IDX_BITS-1:0]                idx,
    output wpc_pkg::item_ctl_t                          ctl_out
);

    localparam int QB = wpc_pkg::IDX_BITS;
    localparam int NS = wpc_pkg::DIV_STAGES;
    localparam int BS = wpc_pkg::BITS_PER_STAGE;

    // Restoring division, BS quotient bits per stage; remainder stays below den.
    logic [SAMPLE_BITS-1:0] rem_src [NS];
    logic [QB-1:0]          quo_src [NS];
    logic [QB-1:0]          low_src [NS];
    logic [SAMPLE_BITS-1:0] den_src [NS];
    logic                   vld_src [NS];
    wpc_pkg::item_ctl_t     ctl_src [NS];

    logic [SAMPLE_BITS-1:0] rem_next [NS];
    logic [QB-1:0]          quo_next [NS];
    logic [QB-1:0]          low_next [NS];

    logic [SAMPLE_BITS-1:0] rem_reg [NS];
    logic [QB-1:0]          quo_reg [NS];
    logic [QB-1:0]          low_reg [NS];
    logic [SAMPLE_BITS-1:0] den_reg [NS];
    logic                   vld_reg [NS];
    wpc_pkg::item_ctl_t     ctl_reg [NS];

    logic [SAMPLE_BITS:0]   rem_twice;
    logic [SAMPLE_BITS:0]   den_ext;
    logic                   round_up;
    logic [QB-1:0]          idx_next;

    logic                   rnd_valid_reg;
    logic [QB-1:0]          idx_reg;
    wpc_pkg::item_ctl_t     rnd_ctl_reg;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign rem_src[s] = prod[SAMPLE_BITS+QB-1:QB];
            assign quo_src[s] = '0;
            assign low_src[s] = prod[QB-1:0];
            assign den_src[s] = den;
            assign vld_src[s] = in_valid;
            assign ctl_src[s] = ctl_in;
        end else begin : g_rest
            assign rem_src[s] = rem_reg[s-1];
            assign quo_src[s] = quo_reg[s-1];
            assign low_src[s] = low_reg[s-1];
            assign den_src[s] = den_reg[s-1];
            assign vld_src[s] = vld_reg[s-1];
            assign ctl_src[s] = ctl_reg[s-1];
        end

        always_comb begin
            logic [SAMPLE_BITS-1:0] r;
            logic [QB-1:0]          q;
            logic [QB-1:0]          lb;
            logic [SAMPLE_BITS:0]   t;
            r = rem_src[s];
            q = quo_src[s];
            lb = low_src[s];
            t = '0;
            for (int j = 0; j < BS; j++) begin
                t  = {r, lb[QB-1]};
                lb = {lb[QB-2:0], 1'b0};
                if (t >= {1'b0, den_src[s]}) begin
                    t = t - {1'b0, den_src[s]};
                    q = {q[QB-2:0], 1'b1};
                end else begin
                    q = {q[QB-2:0], 1'b0};
                end
                r = t[SAMPLE_BITS-1:0];
            end
            rem_next[s] = r;
            quo_next[s] = q;
            low_next[s] = lb;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_src[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
                low_reg[s] <= low_next[s];
                den_reg[s] <= den_src[s];
                ctl_reg[s] <= ctl_src[s];
            end
        end
    end

    // Round half to even on the final remainder.
    always_comb begin
        rem_twice = {rem_reg[NS-1], 1'b0};
        den_ext   = {1'b0, den_reg[NS-1]};
        round_up  = (rem_twice > den_ext) || ((rem_twice == den_ext) && quo_reg[NS-1][0]);
        idx_next  = quo_reg[NS-1] + {{(QB-1){1'b0}}, round_up};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_valid_reg <= 1'b0;
        end else if (en) begin
            rnd_valid_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            idx_reg     <= idx_next;
            rnd_ctl_reg <= ctl_reg[NS-1];
        end
    end

    assign idx_valid = rnd_valid_reg;
    assign idx       = idx_reg;
    assign ctl_out   = rnd_ctl_reg;

    `ASSERT_IMPLIES(idx_within_hot, aclk, aresetn,
        rnd_valid_reg && (rnd_ctl_reg.code == wpc_pkg::CODE_IN), idx_reg <= wpc_pkg::HOT_LAST)
    `ASSERT_IMPLIES(idx_within_gray, aclk, aresetn,
        rnd_valid_reg && (rnd_ctl_reg.code == wpc_pkg::CODE_IN) && (rnd_ctl_reg.scheme == wpc_pkg::SCHEME_GRAY), idx_reg <= wpc_pkg::GRAY_LAST)

endmodule

>>> rtl/wpc_color.sv
`include "assert_macros.svh"

module wpc_color (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    input  logic [wpc_pkg::IDX_BITS-1:0]    idx,
    input  wpc_pkg::item_ctl_t              ctl,
    output logic                            pipe_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,
    output logic [1:0]                      m_tuser
);

    wpc_pkg::color_t color_next;
    logic            take;
    logic            to_skid;

    logic            out_valid_reg;
    wpc_pkg::color_t out_color_reg;
    logic [1:0]      out_code_reg;
    logic            skid_valid_reg;
    wpc_pkg::color_t skid_color_reg;
    logic [1:0]      skid_code_reg;

    assign color_next = wpc_pkg::color_pick(ctl, idx);
    assign pipe_ready = !skid_valid_reg;
    assign take       = in_valid && !skid_valid_reg;
    // Park the new transaction when the output register is held by a stall.
    assign to_skid    = take && out_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (to_skid) begin
            skid_valid_reg <= 1'b1;
        end else if (take) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_color_reg <= skid_color_reg;
                out_code_reg  <= skid_code_reg;
            end
        end else if (to_skid) begin
            skid_color_reg <= color_next;
            skid_code_reg  <= ctl.code;
        end else if (take) begin
            out_color_reg <= color_next;
            out_code_reg  <= ctl.code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_color_reg;
    assign m_tuser  = out_code_reg;

    `ASSERT_IMPLIES(skid_needs_output, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `ASSERT_IMPLIES(skid_fills_on_stall, aclk, aresetn,
        skid_valid_reg && !$past(skid_valid_reg), $past(out_valid_reg && !m_tready))

endmodule

>>> rtl/windowed_pseudocolor_map.sv
// Windowed pseudocolor map: colors a stream of signed samples through a gray, jet, hot
// or cold map (any other scheme gives black) over the window [window_low, window_high]
// set on the cfg port (index 0 scheme, 1 window_low, 2 window_high; write only while
// no transaction is in flight). One sample is taken every clock unless the pipeline
// holds. Each result passes two window/scale stages, five stages of a restoring
// divider at two quotient bits each, a rounding stage and the output register.
// m_tuser carries the window code (0 inside, 1 at or below low, 2 at or above high);
// an output stall is absorbed by a one-entry skid register, so s_tready falls only
// after the result side has held back two transactions.
module windowed_pseudocolor_map #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [1:0]                              cfg_index,
    input  logic [SAMPLE_BITS-1:0]                  cfg_data,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,   // sample
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [23:0]                             m_tdata,   // red, green, blue
    output logic [1:0]                              m_tuser    // window_code
);

    localparam int PW = SAMPLE_BITS + wpc_pkg::IDX_BITS;

    logic [2:0]                    scheme_reg;
    logic signed [SAMPLE_BITS-1:0] win_low_reg;
    logic signed [SAMPLE_BITS-1:0] win_high_reg;

    logic                          en;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          prod_valid;
    logic [PW-1:0]                 prod;
    logic [SAMPLE_BITS-1:0]        den;
    wpc_pkg::item_ctl_t            front_ctl;
    logic                          idx_valid;
    logic [wpc_pkg::IDX_BITS-1:0]  idx;
    wpc_pkg::item_ctl_t            div_ctl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scheme_reg   <= wpc_pkg::SCHEME_GRAY;
            win_low_reg  <= '0;
            win_high_reg <= SAMPLE_BITS'(255);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                wpc_pkg::REG_SCHEME: scheme_reg   <= cfg_data[2:0];
                wpc_pkg::REG_LOW:    win_low_reg  <= cfg_data;
                wpc_pkg::REG_HIGH:   win_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Whole pipeline advances together; it holds only while the skid entry is full.
    assign s_tready = en;
    assign sample   = s_tdata[SAMPLE_BITS-1:0];

    wpc_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_tvalid),
        .sample     (sample),
        .scheme     (scheme_reg),
        .win_low    (win_low_reg),
        .win_high   (win_high_reg),
        .prod_valid (prod_valid),
        .prod       (prod),
        .den        (den),
        .ctl        (front_ctl)
    );

    wpc_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (prod_valid),
        .prod      (prod),
        .den       (den),
        .ctl_in    (front_ctl),
        .idx_valid (idx_valid),
        .idx       (idx),
        .ctl_out   (div_ctl)
    );

    wpc_color u_color (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (idx_valid && en),
        .idx        (idx),
        .ctl        (div_ctl),
        .pipe_ready (en),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

>>> tb/pseudocolor_checker.sv
`timescale 1ns / 100ps

module pseudocolor_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [SAMPLE_BITS-1:0]              cfg_data,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // sample
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [23:0]                         m_tdata,   // red, green, blue
    input  logic [1:0]                          m_tuser,   // window_code
    output int                                  errors,
    output int                                  outstanding
);

    typedef struct packed {
        wpc_pkg::color_t colour;
        logic [1:0]      code;
    } shade_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        shade_t                        shade;
    } colour_job_t;

    logic [2:0]                    map_sel;
    logic signed [SAMPLE_BITS-1:0] win_lo;
    logic signed [SAMPLE_BITS-1:0] win_hi;
    colour_job_t                   colour_q[$];

    function automatic wpc_pkg::color_t rgb8(int r, int g, int b);
        wpc_pkg::color_t c;
        c.red   = 8'(r);
        c.green = 8'(g);
        c.blue  = 8'(b);
        return c;
    endfunction

    // round(span * num / den), ties to even; num < den always holds here
    function automatic int ramp_index(int span, int num, int den);
        longint p;
        longint q;
        longint rem;
        p = longint'(span) * longint'(num);
        q = p / den;
        rem = p % den;
        if (2 * rem > den || (2 * rem == den && q % 2 == 1)) q++;
        return int'(q);
    endfunction

    function automatic wpc_pkg::color_t jet_rgb(int i);
        if (i < 128) return rgb8(0, i, 128 + i);
        if (i < 256) return rgb8(i - 127, i, 382 - i);
        if (i < 383) return rgb8(i - 127, 510 - i, 382 - i);
        if (i < 447) return rgb8(255, 892 - 2 * i, 0);
        return rgb8(1147 - 2 * i, 0, 0);
    endfunction

    function automatic wpc_pkg::color_t hot_rgb(int i);
        if (i < 256) return rgb8(0, i, 255);
        if (i < 511) return rgb8(0, 255, 510 - i);
        if (i < 766) return rgb8(i - 511, 255, 0);
        return rgb8(255, 1021 - i, 0);
    endfunction

    function automatic shade_t colour_of(logic [2:0] sel, logic signed [SAMPLE_BITS-1:0] lo,
                                         logic signed [SAMPLE_BITS-1:0] hi,
                                         logic signed [SAMPLE_BITS-1:0] v);
        shade_t s;
        int     num;
        int     den;
        int     idx;
        num = int'(v) - int'(lo);
        den = int'(hi) - int'(lo);
        s.colour = rgb8(0, 0, 0);
        // low-end test first, so an empty or inverted window never reaches the ramp
        if (v <= lo)      s.code = wpc_pkg::CODE_LOW;
        else if (v >= hi) s.code = wpc_pkg::CODE_HIGH;
        else              s.code = wpc_pkg::CODE_IN;

        case (sel)
            wpc_pkg::SCHEME_GRAY: begin
                if (s.code == wpc_pkg::CODE_HIGH) begin
                    s.colour = rgb8(255, 255, 255);
                end else if (s.code == wpc_pkg::CODE_IN) begin
                    idx = ramp_index(255, num, den);
                    s.colour = rgb8(idx, idx, idx);
                end
            end
            wpc_pkg::SCHEME_JET: begin
                if (s.code == wpc_pkg::CODE_LOW)       s.colour = rgb8(0, 0, 139);
                else if (s.code == wpc_pkg::CODE_HIGH) s.colour = rgb8(139, 0, 0);
                else s.colour = jet_rgb(ramp_index(510, num, den));
            end
            wpc_pkg::SCHEME_HOT: begin
                if (s.code == wpc_pkg::CODE_LOW)       s.colour = rgb8(0, 0, 255);
                else if (s.code == wpc_pkg::CODE_HIGH) s.colour = rgb8(255, 0, 0);
                else s.colour = hot_rgb(ramp_index(1020, num, den));
            end
            wpc_pkg::SCHEME_COLD: begin
                if (s.code == wpc_pkg::CODE_LOW)       s.colour = rgb8(255, 0, 0);
                else if (s.code == wpc_pkg::CODE_HIGH) s.colour = rgb8(0, 0, 255);
                else s.colour = hot_rgb(1020 - ramp_index(1020, num, den));
            end
            default: begin
                // none and the unused codes stay black
            end
        endcase
        return s;
    endfunction

    always @(posedge aclk) begin
        colour_job_t     job;
        wpc_pkg::color_t got;
        if (!aresetn) begin
            map_sel     = wpc_pkg::SCHEME_GRAY;
            win_lo      = '0;
            win_hi      = SAMPLE_BITS'(255);
            colour_q.delete();
            errors      = 0;
            outstanding = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    wpc_pkg::REG_SCHEME: map_sel = cfg_data[2:0];
                    wpc_pkg::REG_LOW:    win_lo  = cfg_data;
                    wpc_pkg::REG_HIGH:   win_hi  = cfg_data;
                    default:             ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                job.sample = s_tdata[SAMPLE_BITS-1:0];
                job.shade  = colour_of(map_sel, win_lo, win_hi, job.sample);
                colour_q.push_back(job);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (colour_q.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result rgb %0d,%0d,%0d code %0d",
                                 got.red, got.green, got.blue, m_tuser);
                    errors++;
                end else begin
                    job = colour_q.pop_front();
                    if (got.red !== job.shade.colour.red
                        || got.green !== job.shade.colour.green
                        || got.blue !== job.shade.colour.blue
                        || m_tuser !== job.shade.code) begin
                        if (errors < 10) begin
                            $write("mismatch for sample %0d: expected rgb %0d,%0d,%0d code %0d, ",
                                   job.sample, job.shade.colour.red,
                                   job.shade.colour.green, job.shade.colour.blue,
                                   job.shade.code);
                            $display("got rgb %0d,%0d,%0d code %0d",
                                     got.red, got.green, got.blue, m_tuser);
                        end
                        errors++;
                    end
                end
            end
            outstanding = colour_q.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int SAMPLE_BITS  = 16;
    localparam int TDATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 400000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [1:0]             cfg_index = wpc_pkg::REG_SCHEME;
    logic [SAMPLE_BITS-1:0] cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_BITS-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [23:0]            m_tdata;
    logic [1:0]             m_tuser;

    int errors;
    int outstanding;
    int cycles  = 0;
    int rx_hold = 0;
    bit steady  = 1'b0;
    int cur_lo;
    int cur_hi;

    always #1 aclk = ~aclk;

    windowed_pseudocolor_map #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    pseudocolor_checker #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) checker_0 (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
        end else if (!steady && $urandom_range(0, 99) < 20) begin
            rx_hold = idle_length();
        end
        m_tready = (rx_hold == 0);
    end

    // all drive tasks start and end at a falling edge
    task automatic write_reg(input logic [1:0] idx, input logic [SAMPLE_BITS-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_map(input logic [2:0] sel, input int lo, input int hi);
        logic [SAMPLE_BITS-4:0] junk;
        // upper bits of the scheme write must be dropped
        junk = ($urandom_range(0, 3) == 0) ? (SAMPLE_BITS - 3)'($urandom) : '0;
        write_reg(wpc_pkg::REG_SCHEME, {junk, sel});
        write_reg(wpc_pkg::REG_LOW, SAMPLE_BITS'(lo));
        write_reg(wpc_pkg::REG_HIGH, SAMPLE_BITS'(hi));
        cur_lo = lo;
        cur_hi = hi;
    endtask

    task automatic send_sample(input int v);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 25) ? idle_length() : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            s_tdata  = TDATA_BITS'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = TDATA_BITS'(SAMPLE_BITS'(v));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    function automatic int pick_sample(int lo, int hi);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (hi - lo >= 2 && r < 70) return lo + 1 + int'($urandom_range(0, hi - lo - 2));
        if (r < 85) begin
            case ($urandom_range(0, 5))
                0:       v = lo - 1;
                1:       v = lo;
                2:       v = lo + 1;
                3:       v = hi - 1;
                4:       v = hi;
                default: v = hi + 1;
            endcase
            if (v < -32768) v = -32768;
            if (v > 32767)  v = 32767;
            return v;
        end
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic random_window(output int lo, output int hi);
        int r;
        int room;
        int span;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            lo   = int'($urandom_range(0, 65534)) - 32768;
            room = 32767 - lo;
            case ($urandom_range(0, 2))
                0:       span = $urandom_range(1, room < 8 ? room : 8);
                1:       span = $urandom_range(1, room < 600 ? room : 600);
                default: span = $urandom_range(1, room);
            endcase
            hi = lo + span;
        end else if (r < 8) begin
            // narrow window pressed against one end of the sample range
            if ($urandom_range(0, 1) == 0) begin
                lo = -32768;
                hi = lo + int'($urandom_range(1, 40));
            end else begin
                hi = 32767;
                lo = hi - int'($urandom_range(1, 40));
            end
        end else begin
            // empty or inverted window
            hi = int'($urandom_range(0, 65535)) - 32768;
            lo = hi + int'($urandom_range(0, 300));
            if (lo > 32767) lo = 32767;
        end
    endtask

    initial begin
        int sent;
        int batch;
        int lo;
        int hi;
        sent = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // gray over the reset window 0..255
        cur_lo = 0;
        cur_hi = 255;
        send_sample(-32768);
        send_sample(32767);
        send_sample(0);
        send_sample(255);
        send_sample(1);
        send_sample(254);
        send_sample(128);
        wait_idle();

        // full sample range as the window
        set_map(wpc_pkg::SCHEME_JET, -32768, 32767);
        send_sample(-32768);
        send_sample(32767);
        send_sample(0);
        wait_idle();
        set_map(wpc_pkg::SCHEME_HOT, -32768, 32767);
        send_sample(-32767);
        send_sample(32766);
        wait_idle();

        // ramp positions that fall exactly halfway between two entries
        set_map(wpc_pkg::SCHEME_GRAY, 0, 6);
        send_sample(1);
        send_sample(3);
        send_sample(5);
        wait_idle();
        set_map(wpc_pkg::SCHEME_COLD, -5, 3);
        send_sample(-4);
        send_sample(2);
        wait_idle();

        // no map selected, empty window
        set_map(wpc_pkg::SCHEME_NONE, 100, 100);
        send_sample(99);
        send_sample(100);
        send_sample(101);
        wait_idle();

        // top unused scheme code, inverted window
        set_map(3'd7, 10, -10);
        send_sample(10);
        send_sample(0);
        send_sample(11);
        wait_idle();

        while (sent < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 4) == 0);
            random_window(lo, hi);
            if ($urandom_range(0, 9) < 8) set_map(3'($urandom_range(0, 3)), lo, hi);
            else                          set_map(3'($urandom_range(4, 7)), lo, hi);
            batch = $urandom_range(20, 60);
            repeat (batch) begin
                send_sample(pick_sample(cur_lo, cur_hi));
                sent++;
            end
            wait_idle();
        end

        steady = 1'b0;
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0 && outstanding == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
